// ----- rtl/core/rmsn_pkg.sv -----
// Shared constants, types and state codes for the RMS normaliser.
`default_nettype none
package rmsn_pkg;

	localparam int MAX_ELEMENTS_DEF = 64;
	localparam int SAMPLE_BITS_DEF  = 16;

	localparam int          WEIGHT_W   = 16;
	localparam int          EPS_W      = 32;
	localparam logic [31:0] EPS_RESET  = 32'd168;
	localparam logic [15:0] WEIGHT_ONE = 16'd16384;

	// Reciprocal root: floor(2^48 / S), at most 2^48.
	localparam int INV_SHIFT = 48;
	localparam int INV_W     = 49;
	localparam int INV_LO_W  = 25;

	// Mean square plus epsilon, the radicand and the root.
	localparam int D_W   = 33;
	localparam int RAD_W = 58;
	localparam int S_W   = RAD_W / 2;

	localparam int PADDR_W = 3;
	localparam logic REG_EPSILON = 1'b0;
	localparam logic REG_APPLY   = 1'b1;

	typedef enum logic {
		DIV_MEAN,
		DIV_INV
	} div_src_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ADD,
		ST_MS_GO,
		ST_MS_WAIT,
		ST_D_CALC,
		ST_RT_GO,
		ST_RT_WAIT,
		ST_INV_GO,
		ST_INV_WAIT,
		ST_INV_LOAD,
		ST_RD,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_M1,
		ST_M2,
		ST_PUT
	} state_t;

	typedef struct packed {
		logic     acc_load;
		logic     acc_add;
		logic     div_start;
		div_src_t div_sel;
		logic     d_load;
		logic     sqrt_start;
		logic     inv_load;
		logic     idx_clr;
		logic     idx_inc;
		logic     rd_en;
		logic     mul_lo;
		logic     mul_hi;
		logic     m1_en;
		logic     m2_en;
		logic     out_load;
		logic     run_clear;
	} cmd_t;

	typedef struct packed {
		logic div_done;
		logic sqrt_done;
		logic last_q;
		logic emit_last;
		logic out_busy;
	} sts_t;

endpackage
`default_nettype wire

// ----- rtl/core/rms_normalizer_unit.sv -----
// Top level of the RMS normaliser: register port, controller and datapath.
`default_nettype none
//
// Channel   Direction  Handshake            Word
// config    in         psel/penable/pready  epsilon at byte 0, apply_weight at byte 4
// input     in         in_valid/in_stall    sample, weight, last
// result    out        out_valid/out_stall  normalized, final_res, overflow
//
// An element is taken in the idle state, stored and squared, and its square is added into
// the running sum in the add state before the next is taken. The element marked last starts
// the root pass: a mean square division and a reciprocal division through the one shared
// divider of width DW = max(2*SAMPLE_BITS+5, 49), with the square root between them.
// Each stored element then runs the scaling steps: read, multiply low and high, m1, m2, put.
// Reset clears the control state and the register defaults; the stores need no clearing.
// A stalled result holds its word; the pass waits on it and input waits until the pass ends.
module rms_normalizer_unit #(
	parameter int MAX_ELEMENTS = rmsn_pkg::MAX_ELEMENTS_DEF,
	parameter int SAMPLE_BITS  = rmsn_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 psel,
	input  wire logic                                 penable,
	input  wire logic                                 pwrite,
	input  wire logic [rmsn_pkg::PADDR_W-1:0]         paddr,
	input  wire logic [31:0]                          pwdata,
	output logic      [31:0]                          prdata,
	output logic                                      pready,
	input  wire logic                                 in_valid,
	output logic                                      in_stall,
	input  wire logic signed [SAMPLE_BITS-1:0]        sample,
	input  wire logic signed [rmsn_pkg::WEIGHT_W-1:0] weight,
	input  wire logic                                 last,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [SAMPLE_BITS-1:0]             normalized,
	output logic                                      final_res,
	output logic                                      overflow
);

	logic [31:0]    epsilon_q;
	logic           apply_q;
	logic           wr_en;
	rmsn_pkg::cmd_t cmd;
	rmsn_pkg::sts_t sts;

	// The port never waits; a write lands at the access cycle. Bit 2 of the address
	// picks the register, the low bits are not decoded.
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epsilon_q <= rmsn_pkg::EPS_RESET;
			apply_q   <= 1'b1;
		end else if (wr_en) begin
			case (paddr[2])
				rmsn_pkg::REG_EPSILON: epsilon_q <= pwdata;
				rmsn_pkg::REG_APPLY:   apply_q   <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			rmsn_pkg::REG_EPSILON: prdata = epsilon_q;
			rmsn_pkg::REG_APPLY:   prdata = {31'd0, apply_q};
			default:               prdata = '0;
		endcase
	end

	rmsn_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	rmsn_datapath #(
		.MAX_ELEMENTS (MAX_ELEMENTS),
		.SAMPLE_BITS  (SAMPLE_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.epsilon      (epsilon_q),
		.apply_weight (apply_q),
		.sample       (sample),
		.weight       (weight),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.normalized   (normalized),
		.final_res    (final_res),
		.overflow     (overflow)
	);

endmodule
`default_nettype wire

// ----- rtl/core/rmsn_div.sv -----
// Iterative restoring divider, one quotient bit per cycle.
`default_nettype none
module rmsn_div #(
	parameter int DW = 49
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [DW-1:0] dividend,
	input  wire logic [DW-1:0] divisor,
	output logic      [DW-1:0] quotient,
	output logic               done
);

	localparam int CW = $clog2(DW);

	logic [DW-1:0] q_q;
	logic [DW-1:0] rem_q;
	logic [DW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [DW:0]   trial;
	logic          fits;

	assign trial = {rem_q, q_q[DW-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
			q_q   <= {q_q[DW-2:0], fits};
		end
	end

	assign quotient = q_q;
	assign done     = done_q;

endmodule
`default_nettype wire

// ----- rtl/core/rmsn_sqrt.sv -----
// Iterative integer square root, one root bit per cycle.
`default_nettype none
module rmsn_sqrt (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      start,
	input  wire logic [rmsn_pkg::RAD_W-1:0] radicand,
	output logic      [rmsn_pkg::S_W-1:0]   root,
	output logic                           done
);

	localparam int RW = rmsn_pkg::RAD_W;
	localparam int NS = rmsn_pkg::S_W;
	localparam int CW = $clog2(NS);

	logic [RW-1:0] v_q;
	logic [RW-1:0] r_q;
	logic [RW-1:0] bit_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [RW-1:0] probe;

	assign probe = r_q + bit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(NS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			v_q   <= radicand;
			r_q   <= '0;
			bit_q <= RW'(1) << (RW - 2);
		end else if (busy_q) begin
			if (v_q >= probe) begin
				v_q <= v_q - probe;
				r_q <= (r_q >> 1) + bit_q;
			end else begin
				r_q <= r_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = r_q[NS-1:0];
	assign done = done_q;

endmodule
`default_nettype wire

// ----- rtl/core/rmsn_datapath.sv -----
// Element stores, sum of squares, root and reciprocal units and the scaling pipeline.
`default_nettype none
module rmsn_datapath #(
	parameter int MAX_ELEMENTS = rmsn_pkg::MAX_ELEMENTS_DEF,
	parameter int SAMPLE_BITS  = rmsn_pkg::SAMPLE_BITS_DEF
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire rmsn_pkg::cmd_t                       cmd,
	output rmsn_pkg::sts_t                            sts,
	input  wire logic [31:0]                          epsilon,
	input  wire logic                                 apply_weight,
	input  wire logic signed [SAMPLE_BITS-1:0]        sample,
	input  wire logic signed [rmsn_pkg::WEIGHT_W-1:0] weight,
	input  wire logic                                 last,
	output logic                                      out_valid,
	input  wire logic                                 out_stall,
	output logic signed [SAMPLE_BITS-1:0]             normalized,
	output logic                                      final_res,
	output logic                                      overflow
);

	localparam int SB     = SAMPLE_BITS;
	localparam int WW     = rmsn_pkg::WEIGHT_W;
	localparam int INV_W  = rmsn_pkg::INV_W;
	localparam int LO_W   = rmsn_pkg::INV_LO_W;
	localparam int HI_W   = INV_W - LO_W;
	localparam int SUM_W  = 2 * SB + 5;
	localparam int DW     = (SUM_W > INV_W) ? SUM_W : INV_W;
	localparam int FULL_W = SB + INV_W;
	localparam int M1W_W  = FULL_W - 24;
	localparam int M1_W   = SB + 15;
	localparam int M2R_W  = M1_W + WW;
	localparam int M2_W   = M2R_W - 14;
	localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
	localparam int IDX_W  = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
	localparam int SQF    = 2 * (SB - 4);
	localparam int DN     = (SQF >= 24) ? SQF - 24 : 0;
	localparam int UP     = (SQF < 24) ? 24 - SQF : 0;

	logic [SB-1:0] smem [MAX_ELEMENTS];
	logic [WW-1:0] wmem [MAX_ELEMENTS];

	logic [CNT_W-1:0]     count_q;
	logic [SUM_W-1:0]     sum_q;
	logic                 ovf_q;
	logic                 last_q;
	logic [2*SB-1:0]      sq_q;
	logic [CNT_W-1:0]     idx_q;
	logic [rmsn_pkg::D_W-1:0] d_q;
	logic [INV_W-1:0]     inv_q;
	logic [SB-1:0]        rd_s_q;
	logic [WW-1:0]        rd_w_q;
	logic [SB-1:0]        ax_q;
	logic [WW-1:0]        aw_q;
	logic                 neg_q;
	logic [SB+LO_W-1:0]   pp_lo_q;
	logic [SB+HI_W-1:0]   pp_hi_q;
	logic [M1_W-1:0]      m1_q;
	logic [M2R_W-1:0]     m2r_q;
	logic                 out_valid_q;
	logic [SB-1:0]        norm_q;
	logic                 final_q;
	logic                 oflag_q;

	logic [SB-1:0]        in_u;
	logic [SB-1:0]        in_mag;
	logic [DW-1:0]        div_a;
	logic [DW-1:0]        div_b;
	logic [DW-1:0]        quot;
	logic                 div_done;
	logic [DW-1:0]        q_al;
	logic [rmsn_pkg::D_W-1:0] d_sum;
	logic [rmsn_pkg::S_W-1:0] root;
	logic [rmsn_pkg::S_W-1:0] root_nz;
	logic                 sqrt_done;
	logic [SB-1:0]        x_mag;
	logic [WW-1:0]        w_eff;
	logic [WW-1:0]        w_mag;
	logic                 w_neg;
	logic [FULL_W-1:0]    full;
	logic [M1W_W-1:0]     m1w;
	logic [M2_W-1:0]      m2;
	logic [SB-1:0]        sat;
	logic                 out_take;

	// Magnitude of the incoming sample; the most negative code maps to 2^(SB-1).
	assign in_u   = sample;
	assign in_mag = in_u[SB-1] ? (~in_u + SB'(1)) : in_u;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
			last_q  <= 1'b0;
		end else if (cmd.run_clear) begin
			count_q <= '0;
			sum_q   <= '0;
			ovf_q   <= 1'b0;
		end else if (cmd.acc_load) begin
			last_q <= last;
			if (count_q < CNT_W'(MAX_ELEMENTS)) begin
				count_q <= count_q + CNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end else if (cmd.acc_add) begin
			sum_q <= sum_q + SUM_W'(sq_q);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.acc_load) begin
			if (count_q < CNT_W'(MAX_ELEMENTS)) begin
				smem[count_q[IDX_W-1:0]] <= sample;
				wmem[count_q[IDX_W-1:0]] <= weight;
				sq_q <= in_mag * in_mag;
			end else begin
				sq_q <= '0;
			end
		end
		if (cmd.rd_en) begin
			rd_s_q <= smem[idx_q[IDX_W-1:0]];
			rd_w_q <= wmem[idx_q[IDX_W-1:0]];
		end
	end

	// Shared divider: mean square first, then the reciprocal of the root.
	assign root_nz = (root == '0) ? rmsn_pkg::S_W'(1) : root;
	assign div_a = (cmd.div_sel == rmsn_pkg::DIV_MEAN) ? DW'(sum_q)
		: (DW'(1) << rmsn_pkg::INV_SHIFT);
	assign div_b = (cmd.div_sel == rmsn_pkg::DIV_MEAN) ? DW'(count_q) : DW'(root_nz);

	rmsn_div #(.DW(DW)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_a),
		.divisor  (div_b),
		.quotient (quot),
		.done     (div_done)
	);

	assign q_al  = (quot >> DN) << UP;
	assign d_sum = {1'b0, q_al[31:0]} + {1'b0, epsilon};

	rmsn_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (rmsn_pkg::RAD_W'({d_q, 24'd0})),
		.root     (root),
		.done     (sqrt_done)
	);

	assign x_mag = rd_s_q[SB-1] ? (~rd_s_q + SB'(1)) : rd_s_q;
	assign w_eff = apply_weight ? rd_w_q : rmsn_pkg::WEIGHT_ONE;
	assign w_neg = w_eff[WW-1];
	assign w_mag = w_neg ? (~w_eff + WW'(1)) : w_eff;

	assign full = (FULL_W'(pp_hi_q) << LO_W) + FULL_W'(pp_lo_q);
	assign m1w  = M1W_W'((full + (FULL_W'(1) << 23)) >> 24);
	assign m2   = M2_W'((m2r_q + (M2R_W'(1) << 13)) >> 14);

	always_comb begin
		if (neg_q) begin
			if (m2 > (M2_W'(1) << (SB - 1))) begin
				sat = {1'b1, {(SB-1){1'b0}}};
			end else begin
				sat = ~m2[SB-1:0] + SB'(1);
			end
		end else begin
			if (m2 > M2_W'({(SB-1){1'b1}})) begin
				sat = {1'b0, {(SB-1){1'b1}}};
			end else begin
				sat = m2[SB-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.d_load) begin
			d_q <= (d_sum == '0) ? rmsn_pkg::D_W'(1) : d_sum;
		end
		if (cmd.inv_load) begin
			inv_q <= quot[INV_W-1:0];
		end
		if (cmd.mul_lo) begin
			ax_q    <= x_mag;
			aw_q    <= w_mag;
			neg_q   <= rd_s_q[SB-1] ^ w_neg;
			pp_lo_q <= x_mag * inv_q[LO_W-1:0];
		end
		if (cmd.mul_hi) begin
			pp_hi_q <= ax_q * inv_q[INV_W-1:LO_W];
		end
		// Clamping m1 keeps every saturating result saturated.
		if (cmd.m1_en) begin
			m1_q <= (m1w > (M1W_W'(1) << (SB + 14))) ? (M1_W'(1) << (SB + 14))
				: M1_W'(m1w);
		end
		if (cmd.m2_en) begin
			m2r_q <= m1_q * aw_q;
		end
		if (cmd.out_load) begin
			norm_q  <= sat;
			final_q <= sts.emit_last;
			oflag_q <= ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	assign out_take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_take) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.div_done  = div_done;
	assign sts.sqrt_done = sqrt_done;
	assign sts.last_q    = last_q;
	assign sts.emit_last = (idx_q + CNT_W'(1)) == count_q;
	assign sts.out_busy  = out_valid_q && out_stall;

	assign out_valid  = out_valid_q;
	assign normalized = norm_q;
	assign final_res  = final_q;
	assign overflow   = oflag_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ELEMENTS))
		else $error("element count beyond buffer depth");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid_q && out_stall))
		else $error("result loaded over a word still waiting");

	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.run_clear |=> (count_q == '0) && !ovf_q && (sum_q == '0))
		else $error("run state not cleared after emit pass");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> (idx_q < count_q))
		else $error("emit pass read beyond stored elements");
`endif

endmodule
`default_nettype wire

// ----- rtl/core/rmsn_ctrl.sv -----
// Sequencing state machine for accumulate, root, reciprocal and emit pass.
`default_nettype none
module rmsn_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire rmsn_pkg::sts_t sts,
	output rmsn_pkg::cmd_t      cmd
);

	rmsn_pkg::state_t state_q;
	rmsn_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rmsn_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		in_stall = 1'b1;
		case (state_q)
			rmsn_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.acc_load = 1'b1;
					state_d      = rmsn_pkg::ST_ADD;
				end
			end
			rmsn_pkg::ST_ADD: begin
				cmd.acc_add = 1'b1;
				state_d     = sts.last_q ? rmsn_pkg::ST_MS_GO : rmsn_pkg::ST_IDLE;
			end
			rmsn_pkg::ST_MS_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = rmsn_pkg::DIV_MEAN;
				state_d       = rmsn_pkg::ST_MS_WAIT;
			end
			rmsn_pkg::ST_MS_WAIT: begin
				if (sts.div_done) begin
					state_d = rmsn_pkg::ST_D_CALC;
				end
			end
			rmsn_pkg::ST_D_CALC: begin
				cmd.d_load = 1'b1;
				state_d    = rmsn_pkg::ST_RT_GO;
			end
			rmsn_pkg::ST_RT_GO: begin
				cmd.sqrt_start = 1'b1;
				state_d        = rmsn_pkg::ST_RT_WAIT;
			end
			rmsn_pkg::ST_RT_WAIT: begin
				if (sts.sqrt_done) begin
					state_d = rmsn_pkg::ST_INV_GO;
				end
			end
			rmsn_pkg::ST_INV_GO: begin
				cmd.div_start = 1'b1;
				cmd.div_sel   = rmsn_pkg::DIV_INV;
				state_d       = rmsn_pkg::ST_INV_WAIT;
			end
			rmsn_pkg::ST_INV_WAIT: begin
				if (sts.div_done) begin
					state_d = rmsn_pkg::ST_INV_LOAD;
				end
			end
			rmsn_pkg::ST_INV_LOAD: begin
				cmd.inv_load = 1'b1;
				cmd.idx_clr  = 1'b1;
				state_d      = rmsn_pkg::ST_RD;
			end
			rmsn_pkg::ST_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = rmsn_pkg::ST_MUL_LO;
			end
			rmsn_pkg::ST_MUL_LO: begin
				cmd.mul_lo = 1'b1;
				state_d    = rmsn_pkg::ST_MUL_HI;
			end
			rmsn_pkg::ST_MUL_HI: begin
				cmd.mul_hi = 1'b1;
				state_d    = rmsn_pkg::ST_M1;
			end
			rmsn_pkg::ST_M1: begin
				cmd.m1_en = 1'b1;
				state_d   = rmsn_pkg::ST_M2;
			end
			rmsn_pkg::ST_M2: begin
				cmd.m2_en = 1'b1;
				state_d   = rmsn_pkg::ST_PUT;
			end
			rmsn_pkg::ST_PUT: begin
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					if (sts.emit_last) begin
						cmd.run_clear = 1'b1;
						state_d       = rmsn_pkg::ST_IDLE;
					end else begin
						cmd.idx_inc = 1'b1;
						state_d     = rmsn_pkg::ST_RD;
					end
				end
			end
			default: begin
				state_d = rmsn_pkg::ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

// ----- bench/tb_rms_normalizer_unit.sv -----
// Self-checking testbench for the RMS normaliser unit.
`timescale 1ns / 100ps
`default_nettype none
module tb_rms_normalizer_unit;

	localparam int DEPTH     = 64;
	localparam int SBITS     = 16;
	localparam int STALL_MAX = 5000;

	// One expected normalised word as it should leave the block.
	typedef struct {
		logic signed [SBITS-1:0] norm;
		logic                    fin;
		logic                    ovf;
	} norm_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [rmsn_pkg::PADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [SBITS-1:0] sample = '0;
	logic signed [rmsn_pkg::WEIGHT_W-1:0] weight = '0;
	logic last = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [SBITS-1:0] normalized;
	logic final_res, overflow;

	always #4 clk = ~clk;

	rms_normalizer_unit dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.sample(sample), .weight(weight), .last(last),
		.out_valid(out_valid), .out_stall(out_stall),
		.normalized(normalized), .final_res(final_res), .overflow(overflow)
	);

	// The predictor keeps its own copy of the register settings and the vector state.
	logic [31:0]        eps_q = rmsn_pkg::EPS_RESET;
	logic               wt_on_q = 1'b1;
	logic [SBITS-1:0]   samp_mem [DEPTH];
	logic [15:0]        wgt_mem [DEPTH];
	int unsigned        elem_cnt = 0;
	logic [63:0]        sq_acc = '0;
	logic               trunc_seen = 1'b0;
	norm_word_t         pending_norm [$];

	int n_errors = 0, n_checked = 0, n_sent = 0, n_vectors = 0, n_overflow_runs = 0;
	int idle_cycles = 0;
	int hold_cycles = 0;
	bit quiet_rx = 1'b0;
	bit apb_fire = 1'b0;

	// Integer square root by the classic bit-pair method.
	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] r, b;
		r = '0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// Takes one accepted element; on the last one it queues the whole normalised vector.
	task automatic predict_element(input logic signed [SBITS-1:0] x,
			input logic signed [15:0] w, input logic lst);
		logic [63:0] ax, aw, ms, d, s, inv, m1, m2;
		logic signed [SBITS-1:0] xv;
		logic signed [15:0] wv;
		logic neg;
		norm_word_t nw;
		if (elem_cnt < DEPTH) begin
			ax = x < 0 ? 64'(-int'(x)) : 64'(x);
			samp_mem[elem_cnt] = x;
			wgt_mem[elem_cnt] = w;
			sq_acc += ax * ax;
			elem_cnt++;
		end else begin
			trunc_seen = 1'b1;
		end
		if (!lst) return;
		n_vectors++;
		if (trunc_seen) n_overflow_runs++;
		if (elem_cnt != 0) begin
			// Square sum is already Q.24 for 12 fraction bits, so no realignment is needed.
			ms = sq_acc / elem_cnt;
			d = ms + eps_q;
			if (d == 0) d = 1;
			s = int_sqrt(d << 24);
			if (s == 0) s = 1;
			inv = (64'd1 << 48) / s;
			for (int i = 0; i < elem_cnt; i++) begin
				xv = samp_mem[i];
				wv = wt_on_q ? signed'(wgt_mem[i]) : signed'(rmsn_pkg::WEIGHT_ONE);
				neg = (xv < 0) != (wv < 0);
				ax = xv < 0 ? 64'(-int'(xv)) : 64'(xv);
				aw = wv < 0 ? 64'(-int'(wv)) : 64'(wv);
				m1 = (ax * inv + (64'd1 << 23)) >> 24;
				m2 = (m1 * aw + (64'd1 << 13)) >> 14;
				if (neg) nw.norm = (m2 > 64'd32768) ? -16'sd32768 : SBITS'(-m2);
				else nw.norm = (m2 > 64'd32767) ? 16'sd32767 : SBITS'(m2);
				nw.fin = (i + 1 == elem_cnt);
				nw.ovf = trunc_seen;
				pending_norm.push_back(nw);
			end
		end
		elem_cnt = 0;
		sq_acc = '0;
		trunc_seen = 1'b0;
	endtask

	// Result side: the stall pattern is driven at the rising edge and sampled
	// at the falling edge, where everything has settled.
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			out_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else if (quiet_rx) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(0, 99) < 25);
		end
	end

	always @(negedge clk) begin
		norm_word_t nw;
		if (arst_n && out_valid && !out_stall) begin
			n_checked++;
			if (pending_norm.size() == 0) begin
				n_errors++;
				if (n_errors <= 10)
					$display("unexpected word: norm=%0d fin=%b ovf=%b",
						normalized, final_res, overflow);
			end else begin
				nw = pending_norm.pop_front();
				if (nw.norm !== normalized || nw.fin !== final_res || nw.ovf !== overflow) begin
					n_errors++;
					if (n_errors <= 10)
						$display("mismatch: exp norm=%0d fin=%b ovf=%b, got norm=%0d fin=%b ovf=%b",
							nw.norm, nw.fin, nw.ovf, normalized, final_res, overflow);
				end
			end
		end
	end

	// Watchdog: counts cycles in which no handshake of any kind completes.
	always @(negedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || apb_fire || !arst_n)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_MAX) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Mostly no gap, sometimes a short one, now and then a long one.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (quiet_rx || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offers one element and returns at the edge where it is accepted.
	task automatic send_element(input logic signed [SBITS-1:0] x,
			input logic signed [15:0] w, input logic lst);
		int gap;
		logic stalled;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= x;
		weight <= w;
		last <= lst;
		forever begin
			@(negedge clk);
			stalled = in_stall;
			@(posedge clk);
			if (!stalled) break;
		end
		predict_element(x, w, lst);
		n_sent++;
	endtask

	task automatic end_stream();
		in_valid <= 1'b0;
	endtask

	// Waits until every queued word has arrived and the root pass has surely finished.
	task automatic drain();
		end_stream();
		while (pending_norm.size() != 0) @(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic reg_write(input logic [rmsn_pkg::PADDR_W-1:0] addr,
			input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		apb_fire = 1'b1;
		@(posedge clk);
		apb_fire = 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == {rmsn_pkg::REG_EPSILON, 2'b00}) eps_q = val;
		else wt_on_q = val[0];
	endtask

	task automatic set_regs(input logic [31:0] eps, input logic wt_on);
		reg_write({rmsn_pkg::REG_EPSILON, 2'b00}, eps);
		reg_write({rmsn_pkg::REG_APPLY, 2'b00}, {31'd0, wt_on});
	endtask

	task automatic send_random_vector(input int len);
		for (int i = 0; i < len; i++)
			send_element(SBITS'($urandom), 16'($urandom), i == len - 1);
	endtask

	// Extreme samples and weights at reset settings, then the zero denominator case.
	task automatic test_directed_extremes();
		send_element(16'sh7FFF, 16'sh7FFF, 1'b1);
		send_element(-16'sh8000, -16'sh8000, 1'b1);
		send_element(16'sh7FFF, -16'sh8000, 1'b0);
		send_element(-16'sh8000, 16'sh7FFF, 1'b0);
		send_element(16'sh0001, 16'sh4000, 1'b0);
		send_element(16'sh0000, 16'sh0000, 1'b1);
		send_element(16'sh1000, 16'sh4000, 1'b0);
		send_element(-16'sh1000, -16'sh4000, 1'b0);
		send_element(16'sh5555, 16'shAAAA, 1'b1);
		drain();
		// With epsilon cleared an all-zero vector leaves the denominator at zero.
		set_regs(32'd0, 1'b1);
		send_element(16'sh0000, 16'sh7FFF, 1'b0);
		send_element(16'sh0000, -16'sh8000, 1'b1);
		send_element(16'sh0001, 16'sh4000, 1'b0);
		send_element(16'sh0000, 16'sh4000, 1'b1);
		drain();
	endtask

	// Weighting switched off, with epsilon first at its upper extreme and then at 2^24.
	task automatic test_unweighted_large_eps();
		set_regs(32'hFFFF_FFFF, 1'b0);
		send_element(16'sh7FFF, 16'sh1234, 1'b0);
		send_element(-16'sh8000, -16'sh0001, 1'b1);
		send_random_vector(4);
		drain();
		set_regs(32'h0100_0000, 1'b0);
		send_element(16'sh0800, 16'sh0000, 1'b0);
		send_element(-16'sh0800, 16'sh7FFF, 1'b1);
		send_random_vector(3);
		drain();
	endtask

	// A full vector, then one past the store depth whose surplus is dropped,
	// including a dropped element that carries the end marker.
	task automatic test_truncation();
		set_regs(rmsn_pkg::EPS_RESET, 1'b1);
		send_random_vector(DEPTH);
		send_random_vector(DEPTH + 3);
		drain();
	endtask

	// Receiver holds off for a long stretch while the sender keeps offering.
	task automatic test_backpressure();
		hold_cycles = 400;
		quiet_rx = 1'b1;
		for (int v = 0; v < 3; v++) send_random_vector(6);
		quiet_rx = 1'b0;
		drain();
	endtask

	// Random vectors, mostly short, with register changes between phases.
	task automatic test_random_vectors();
		int len;
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					set_regs(32'($urandom_range(0, 4096)), 1'b1);
				end
				1: begin
					set_regs($urandom, 1'b0);
				end
				2: begin
					set_regs(32'd0, 1'b1);
				end
				default: begin
					set_regs($urandom, 1'($urandom));
				end
			endcase
			// Phase 2 runs with the receiver never stalling.
			quiet_rx = (phase == 2);
			for (int v = 0; v < 4; v++) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 16)
					: $urandom_range(1, 6);
				send_random_vector(len);
			end
			quiet_rx = 1'b0;
			drain();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_extremes();
		test_unweighted_large_eps();
		test_truncation();
		test_backpressure();
		test_random_vectors();
		$display("Run covered %0d elements in %0d vectors (%0d truncated) and %0d checked words.",
			n_sent, n_vectors, n_overflow_runs, n_checked);
		if (n_errors > 0) $display("Mismatches counted: %0d", n_errors);
		if (n_errors == 0 && pending_norm.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
